### sv/rct_pkg.sv
// ============================================================================
// rct_pkg: shared constants for the raised-cosine taper
// Field widths, register indexes, region codes and the Taylor divisors used
// to build the quarter-wave cosine table at elaboration.
// ============================================================================
package rct_pkg;

    // Default table shape
    localparam int COS_TABLE_DEPTH_DEF = 256;
    localparam int COS_FRAC_BITS_DEF   = 15;

    // Field widths
    localparam int X_W   = 24;  // unsigned Q8.16
    localparam int Y_W   = 32;  // signed Q16.16
    localparam int REG_W = 24;
    localparam int IDX_REG_W = 2;
    localparam int REGION_W  = 2;

    // Register indexes
    localparam logic [IDX_REG_W-1:0] REG_TAPER_START  = 2'd0;
    localparam logic [IDX_REG_W-1:0] REG_TAPER_END    = 2'd1;
    localparam logic [IDX_REG_W-1:0] REG_INVERSE_SPAN = 2'd2;

    // Region codes
    localparam logic [REGION_W-1:0] REGION_PASS  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_TAPER = 2'd1;
    localparam logic [REGION_W-1:0] REGION_ZERO  = 2'd2;

    // pi/2 in Q30, and (2n-1)*2n for the twelve Taylor terms
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [63:0] TAYLOR_DIV [0:TAYLOR_TERMS-1] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

endpackage

### sv/raised_cosine_taper_top.sv
// ============================================================================
// raised_cosine_taper_top: streaming raised-cosine taper
// Scales each sample by 0.5*(1+cos(pi*p)) inside the taper band, zeroes it
// at and beyond the band end and passes it unchanged at or before the band start.
// ============================================================================
//
// Usage
//   Input channel: i_radius (unsigned Q8.16) and i_sample_value (signed
//   Q16.16), handshake i_in_valid / o_in_ready. Output channel:
//   o_tapered_value (signed Q16.16, saturated) and o_region, handshake
//   o_out_valid / i_out_ready. A word moves when valid and ready are high.
//   Configuration: write taper_start, taper_end and inverse_span
//   (= 1/(end-start), Q8.16) through i_cfg_we / i_cfg_index / i_cfg_data
//   while no word is in flight; writes to index 3 are dropped.
//   Pipeline: there are seven register stages (compare, phase multiply,
//   phase/mirror, table read, interpolation, sample multiply,
//   round/saturate); the first one loads at the accepting edge itself.
//   Throughput: one word per cycle while the output is not stalled; the
//   phase and sample multipliers and the two-port table read are each
//   used once per word.
//   Reset (i_rst_n low, synchronous): all stage valid bits drop and the
//   three registers return to zero. The cosine table is a constant.
//   Stall: each stage holds while it is full and the stage after it is
//   blocked; empty stages keep filling, so bubbles are squeezed out and
//   o_in_ready only drops once every stage holds a word.
//
module raised_cosine_taper_top
    import rct_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
    parameter int COS_FRAC_BITS   = COS_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [IDX_REG_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [X_W-1:0]        i_radius,
    input  logic signed [Y_W-1:0] i_sample_value,
    // output words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [Y_W-1:0] o_tapered_value,
    output logic [REGION_W-1:0]   o_region
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int F      = COS_FRAC_BITS;
    localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);   // table address 0..DEPTH
    localparam int POS_W  = IDX_W + 17;                     // phase * 2*DEPTH, Q.16
    localparam int PH_W   = 17;                             // phase 0..1.0 in Q.16
    localparam int MUL1_W = 2 * X_W;                        // d * inverse_span
    localparam int CW     = F + 1;                          // table entry, Q1.F
    localparam int DF_W   = CW + 17;                        // diff*f plus rounding carry
    localparam int W2_W   = F + 2;                          // 2^F + cos, 0..2^(F+1)
    localparam int PR_W   = Y_W + F + 3;                    // y * w2, signed
    localparam int R_W    = PR_W - F;                       // rounded magnitude

    localparam logic [POS_W-1:0] TWO_DEPTH = POS_W'(2 * COS_TABLE_DEPTH);
    localparam logic [POS_W-1:0] SPAN_Q16  = POS_W'(COS_TABLE_DEPTH) << 16;
    localparam logic [POS_W-1:0] TWO_SPAN  = POS_W'(COS_TABLE_DEPTH) << 17;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(COS_TABLE_DEPTH);
    localparam logic [W2_W-1:0]  COS_ONE   = W2_W'(1) << F;

    // ------------------------------------------------------------------
    // Quarter-wave cosine table, built at elaboration by a Q30 Taylor series
    // ------------------------------------------------------------------
    typedef logic [CW-1:0] t_cos_rom [0:COS_TABLE_DEPTH];

    function automatic t_cos_rom build_cos_rom();
        t_cos_rom           tab;
        logic [63:0]        th;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        e;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            th   = (HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
            t2   = (th * th) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = ((term * t2) >> 30) / TAYLOR_DIV[n-1];
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > $signed(64'd1 << 30)) begin
                sum = $signed(64'd1 << 30);
            end
            e = ($unsigned(sum) + (64'd1 << (29 - F))) >> (30 - F);
            if (e > (64'd1 << F)) begin
                e = 64'd1 << F;
            end
            tab[k] = e[CW-1:0];
        end
        return tab;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] r_taper_start;
    logic [REG_W-1:0] r_taper_end;
    logic [REG_W-1:0] r_inverse_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taper_start  <= '0;
            r_taper_end    <= '0;
            r_inverse_span <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TAPER_START:  r_taper_start  <= i_cfg_data;
                REG_TAPER_END:    r_taper_end    <= i_cfg_data;
                REG_INVERSE_SPAN: r_inverse_span <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage load enables
    // A stage loads when it is empty or the stage after it loads.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v;
    logic en1, en2, en3, en4, en5, en6, en7;

    assign en7 = !r_s7_v || i_out_ready;
    assign en6 = !r_s6_v || en7;
    assign en5 = !r_s5_v || en6;
    assign en4 = !r_s4_v || en5;
    assign en3 = !r_s3_v || en4;
    assign en2 = !r_s2_v || en3;
    assign en1 = !r_s1_v || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_s7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= i_in_valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en4) begin
                r_s4_v <= r_s3_v;
            end
            if (en5) begin
                r_s5_v <= r_s4_v;
            end
            if (en6) begin
                r_s6_v <= r_s5_v;
            end
            if (en7) begin
                r_s7_v <= r_s6_v;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify radius against the band, form offset into the band
    // ------------------------------------------------------------------
    logic [REGION_W-1:0]   n_s1_region;
    logic [X_W-1:0]        n_s1_d;
    logic [REGION_W-1:0]   r_s1_region;
    logic [X_W-1:0]        r_s1_d;
    logic signed [Y_W-1:0] r_s1_y;

    always_comb begin
        if (i_radius >= r_taper_end) begin
            n_s1_region = REGION_ZERO;
        end else if (i_radius > r_taper_start) begin
            n_s1_region = REGION_TAPER;
        end else begin
            n_s1_region = REGION_PASS;
        end
        n_s1_d = i_radius - r_taper_start;
    end

    // ------------------------------------------------------------------
    // Stage 2: phase product d * inverse_span (Q16.32)
    // ------------------------------------------------------------------
    logic [MUL1_W-1:0]     n_s2_prod;
    logic [MUL1_W-1:0]     r_s2_prod;
    logic [REGION_W-1:0]   r_s2_region;
    logic signed [Y_W-1:0] r_s2_y;

    assign n_s2_prod = MUL1_W'(r_s1_d) * MUL1_W'(r_inverse_span);

    // ------------------------------------------------------------------
    // Stage 3: round and clamp phase, scale to table position, fold at pi/2
    // ------------------------------------------------------------------
    logic [MUL1_W:0]       n_s3_rnd;
    logic [PH_W-1:0]       n_s3_ph;
    logic [POS_W-1:0]      n_s3_pos;
    logic [POS_W-1:0]      n_s3_m;
    logic                  n_s3_neg;
    logic [IDX_W-1:0]      r_s3_i;
    logic [15:0]           r_s3_f;
    logic                  r_s3_neg;
    logic [REGION_W-1:0]   r_s3_region;
    logic signed [Y_W-1:0] r_s3_y;

    always_comb begin
        n_s3_rnd = {1'b0, r_s2_prod} + (MUL1_W + 1)'(32768);
        if (n_s3_rnd[MUL1_W:16] > (MUL1_W - 15)'(65536)) begin
            n_s3_ph = PH_W'(65536);
        end else begin
            n_s3_ph = n_s3_rnd[16+PH_W-1:16];
        end
        n_s3_pos = POS_W'(n_s3_ph) * TWO_DEPTH;
        // Second quarter: cos(pi - a) = -cos(a)
        n_s3_neg = (n_s3_pos >= SPAN_Q16);
        n_s3_m   = n_s3_neg ? (TWO_SPAN - n_s3_pos) : n_s3_pos;
    end

    // ------------------------------------------------------------------
    // Stage 4: read the two neighboring table entries
    // ------------------------------------------------------------------
    logic [CW-1:0]         n_s4_a;
    logic [CW-1:0]         n_s4_b;
    logic [CW-1:0]         r_s4_a;
    logic [CW-1:0]         r_s4_b;
    logic [15:0]           r_s4_f;
    logic                  r_s4_neg;
    logic [REGION_W-1:0]   r_s4_region;
    logic signed [Y_W-1:0] r_s4_y;

    always_comb begin
        if (r_s3_i >= LAST_IDX) begin
            // End of the table: no slope to interpolate
            n_s4_a = COS_ROM[LAST_IDX];
            n_s4_b = COS_ROM[LAST_IDX];
        end else begin
            n_s4_a = COS_ROM[r_s3_i];
            n_s4_b = COS_ROM[r_s3_i + IDX_W'(1)];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: linear interpolation, then weight w2 = 2^F +/- cos
    // ------------------------------------------------------------------
    logic [CW-1:0]         n_s5_diff;
    logic [DF_W-1:0]       n_s5_df;
    logic [CW-1:0]         n_s5_q;
    logic [W2_W-1:0]       n_s5_w2;
    logic [W2_W-1:0]       r_s5_w2;
    logic [REGION_W-1:0]   r_s5_region;
    logic signed [Y_W-1:0] r_s5_y;

    always_comb begin
        // A rising step counts as flat
        n_s5_diff = (r_s4_a >= r_s4_b) ? (r_s4_a - r_s4_b) : '0;
        n_s5_df   = DF_W'(n_s5_diff) * DF_W'(r_s4_f) + DF_W'(32768);
        n_s5_q    = r_s4_a - n_s5_df[16+CW-1:16];
        n_s5_w2   = r_s4_neg ? (COS_ONE - W2_W'(n_s5_q)) : (COS_ONE + W2_W'(n_s5_q));
    end

    // ------------------------------------------------------------------
    // Stage 6: sample times weight
    // ------------------------------------------------------------------
    logic signed [PR_W-1:0] n_s6_prod;
    logic signed [PR_W-1:0] r_s6_prod;
    logic [REGION_W-1:0]    r_s6_region;
    logic signed [Y_W-1:0]  r_s6_y;

    assign n_s6_prod = PR_W'(r_s5_y) * PR_W'($signed({1'b0, r_s5_w2}));

    // ------------------------------------------------------------------
    // Stage 7: round half away from zero, saturate, select by region
    // ------------------------------------------------------------------
    logic                  n_s7_neg;
    logic [PR_W-1:0]       n_s7_mag;
    logic [PR_W:0]         n_s7_rnd;
    logic [R_W-1:0]        n_s7_r;
    logic signed [Y_W-1:0] n_s7_sat;
    logic signed [Y_W-1:0] n_s7_val;
    logic signed [Y_W-1:0] r_s7_val;
    logic [REGION_W-1:0]   r_s7_region;

    always_comb begin
        n_s7_neg = r_s6_prod[PR_W-1];
        n_s7_mag = n_s7_neg ? (PR_W'(0) - $unsigned(r_s6_prod)) : $unsigned(r_s6_prod);
        n_s7_rnd = {1'b0, n_s7_mag} + ((PR_W + 1)'(1) << F);
        n_s7_r   = n_s7_rnd[PR_W:F+1];
        if (n_s7_neg) begin
            if (n_s7_r > R_W'(33'h0_8000_0000)) begin
                n_s7_sat = $signed(32'h8000_0000);
            end else begin
                n_s7_sat = $signed(32'd0 - n_s7_r[Y_W-1:0]);
            end
        end else begin
            if (n_s7_r > R_W'(33'h0_7FFF_FFFF)) begin
                n_s7_sat = $signed(32'h7FFF_FFFF);
            end else begin
                n_s7_sat = $signed(n_s7_r[Y_W-1:0]);
            end
        end
        case (r_s6_region)
            REGION_TAPER: n_s7_val = n_s7_sat;
            REGION_ZERO:  n_s7_val = '0;
            default:      n_s7_val = r_s6_y;
        endcase
    end

    // ------------------------------------------------------------------
    // Payload registers: advance with their stage enables
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_region <= n_s1_region;
            r_s1_d      <= n_s1_d;
            r_s1_y      <= i_sample_value;
        end
        if (en2) begin
            r_s2_prod   <= n_s2_prod;
            r_s2_region <= r_s1_region;
            r_s2_y      <= r_s1_y;
        end
        if (en3) begin
            r_s3_i      <= n_s3_m[16+IDX_W-1:16];
            r_s3_f      <= n_s3_m[15:0];
            r_s3_neg    <= n_s3_neg;
            r_s3_region <= r_s2_region;
            r_s3_y      <= r_s2_y;
        end
        if (en4) begin
            r_s4_a      <= n_s4_a;
            r_s4_b      <= n_s4_b;
            r_s4_f      <= r_s3_f;
            r_s4_neg    <= r_s3_neg;
            r_s4_region <= r_s3_region;
            r_s4_y      <= r_s3_y;
        end
        if (en5) begin
            r_s5_w2     <= n_s5_w2;
            r_s5_region <= r_s4_region;
            r_s5_y      <= r_s4_y;
        end
        if (en6) begin
            r_s6_prod   <= n_s6_prod;
            r_s6_region <= r_s5_region;
            r_s6_y      <= r_s5_y;
        end
        if (en7) begin
            r_s7_val    <= n_s7_val;
            r_s7_region <= r_s6_region;
        end
    end

    assign o_tapered_value = r_s7_val;
    assign o_region        = r_s7_region;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for raised_cosine_taper_top
// Drives sample words through the valid/ready input channel under several
// band settings. A scoreboard class predicts each tapered word with its own
// quarter-wave cosine table and checks output words in order, field by
// field. Both channels idle at random, and the receiver holds off once long
// enough to back the pipeline up into the input.
// ============================================================================
module testbench;
    import rct_pkg::*;

    localparam int COS_DEPTH   = COS_TABLE_DEPTH_DEF;
    localparam int COS_FRAC    = COS_FRAC_BITS_DEF;
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 6;
    localparam int PHASE_WORDS  = 75;
    localparam int LONG_HOLD    = 150;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [IDX_REG_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [Y_W-1:0]  value;
        logic [REGION_W-1:0]    region;
    } t_taper_word;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the band registers and the cosine
    // table, predicts one word per accepted sample and checks words in order.
    // ------------------------------------------------------------------------
    class t_taper_scoreboard;
        logic [REG_W-1:0] taper_start;
        logic [REG_W-1:0] taper_end;
        logic [REG_W-1:0] inverse_span;
        bit [31:0]        cos_rom [0:COS_DEPTH];
        t_taper_word      expected_words [$];
        int               errors;

        function new();
            bit [63:0] th;
            bit [63:0] t2;
            bit [63:0] term;
            bit [63:0] e;
            longint    sum;
            // Build the quarter wave with a fixed-point Taylor series
            for (int k = 0; k <= COS_DEPTH; k++) begin
                th = (HALF_PI_Q30 * k + COS_DEPTH / 2) / COS_DEPTH;
                t2 = (th * th) >> 30;
                term = 64'd1 << 30;
                sum = longint'(term);
                for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                    term = ((term * t2) >> 30) / ((2 * n - 1) * (2 * n));
                    if (n % 2 == 1) sum -= longint'(term);
                    else sum += longint'(term);
                end
                if (sum < 0) sum = 0;
                if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
                e = (64'(sum) + (64'd1 << (29 - COS_FRAC))) >> (30 - COS_FRAC);
                if (e > (64'd1 << COS_FRAC)) e = 64'd1 << COS_FRAC;
                cos_rom[k] = e[31:0];
            end
            taper_start  = '0;
            taper_end    = '0;
            inverse_span = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [IDX_REG_W-1:0] index, logic [REG_W-1:0] data);
            case (index)
                REG_TAPER_START:  taper_start  = data;
                REG_TAPER_END:    taper_end    = data;
                REG_INVERSE_SPAN: inverse_span = data;
                default: ;
            endcase
        endfunction

        // Interpolated quarter-wave cosine at a Q.16 table position
        function bit [31:0] quarter_cos(bit [63:0] m);
            bit [63:0] idx;
            bit [63:0] frac;
            bit [31:0] a;
            bit [31:0] b;
            bit [63:0] diff;
            idx  = m >> 16;
            frac = m & 64'hFFFF;
            if (idx >= COS_DEPTH) return cos_rom[COS_DEPTH];
            a = cos_rom[idx];
            b = cos_rom[idx + 1];
            diff = (a >= b) ? 64'(a - b) : 64'd0;
            return a - 32'((diff * frac + 64'd32768) >> 16);
        endfunction

        function t_taper_word taper_sample(logic [X_W-1:0] radius,
                                           logic signed [Y_W-1:0] value);
            t_taper_word w;
            bit [X_W-1:0] offset;
            bit [63:0]    phase;
            bit [63:0]    pos;
            bit [63:0]    span_q16;
            bit [63:0]    mag;
            bit [63:0]    r;
            longint       c;
            longint       weight2;
            longint       prod;
            logic [31:0]  v32;
            if (radius >= taper_end) begin
                w.value  = '0;
                w.region = REGION_ZERO;
            end else if (radius > taper_start) begin
                offset = radius - taper_start;
                phase = (64'(offset) * 64'(inverse_span) + 64'd32768) >> 16;
                if (phase > 64'd65536) phase = 64'd65536;
                pos = phase * (2 * COS_DEPTH);
                span_q16 = 64'(COS_DEPTH) << 16;
                // Mirror the upper half: cos(pi - a) = -cos(a)
                if (pos < span_q16) c = longint'({32'd0, quarter_cos(pos)});
                else c = -longint'({32'd0, quarter_cos(2 * span_q16 - pos)});
                weight2 = (longint'(1) << COS_FRAC) + c;
                prod = longint'(value) * weight2;
                mag = (prod < 0) ? -prod : prod;
                r = (mag + (64'd1 << COS_FRAC)) >> (COS_FRAC + 1);
                if (prod < 0) begin
                    if (r > 64'h8000_0000) r = 64'h8000_0000;
                    v32 = -r[31:0];
                end else begin
                    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
                    v32 = r[31:0];
                end
                w.value  = v32;
                w.region = REGION_TAPER;
            end else begin
                w.value  = value;
                w.region = REGION_PASS;
            end
            return w;
        endfunction

        function void accept_sample(logic [X_W-1:0] radius, logic signed [Y_W-1:0] value);
            expected_words.insert(expected_words.size(), taper_sample(radius, value));
        endfunction

        function void check_word(logic signed [Y_W-1:0] value, logic [REGION_W-1:0] region);
            t_taper_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: tapered_value %0d region %0d", value, region);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (value !== want.value) begin
                $error("tapered_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (region !== want.region) begin
                $error("region: expected %0d, actual %0d", want.region, region);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_REG_W-1:0]  cfg_index = REG_TAPER_START;
    logic [REG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [X_W-1:0]        radius = '0;
    logic signed [Y_W-1:0] sample_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [Y_W-1:0] tapered_value;
    logic [REGION_W-1:0]   region;

    t_taper_scoreboard sb;

    // Idling knobs, set per phase by the stimulus process
    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    // Long hold-off: the stimulus bumps the request, the sink acknowledges
    int hold_requests = 0;
    int holds_taken   = 0;

    always #HALF_PERIOD clk = ~clk;

    raised_cosine_taper_top #(
        .COS_TABLE_DEPTH (COS_DEPTH),
        .COS_FRAC_BITS   (COS_FRAC)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_radius        (radius),
        .i_sample_value  (sample_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_tapered_value (tapered_value),
        .o_region        (region)
    );

    // ------------------------------------------------------------------------
    // Sender side. Tasks are entered just after a rising edge.
    // ------------------------------------------------------------------------

    // Offer one word after a random gap and hold it until the block takes it.
    // With no gap, valid simply stays high and only the payload advances.
    task automatic send_word(input logic [X_W-1:0] r, input logic signed [Y_W-1:0] v);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        radius       <= r;
        sample_value <= v;
        do @(posedge clk); while (!in_ready);
        sb.accept_sample(r, v);
    endtask

    // Drop valid and wait until every predicted word has come out.
    // Poll on the falling edge so the count is settled, then realign.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Write all three band registers back to back, then a dropped write to
    // the unused index with random data.
    task automatic program_taper(input logic [REG_W-1:0] start_r,
                                 input logic [REG_W-1:0] end_r,
                                 input logic [REG_W-1:0] inv_r);
        logic [REG_W-1:0] junk;
        junk = REG_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TAPER_START;
        cfg_data  <= start_r;
        @(posedge clk);
        cfg_index <= REG_TAPER_END;
        cfg_data  <= end_r;
        @(posedge clk);
        cfg_index <= REG_INVERSE_SPAN;
        cfg_data  <= inv_r;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(REG_TAPER_START, start_r);
        sb.write_reg(REG_TAPER_END, end_r);
        sb.write_reg(REG_INVERSE_SPAN, inv_r);
        sb.write_reg(REG_UNUSED, junk);
    endtask

    // Random band; a consistent one carries the rounded reciprocal of its span
    task automatic program_random_band(input bit consistent);
        logic [REG_W-1:0] s;
        logic [REG_W-1:0] span;
        logic [REG_W-1:0] inv;
        bit [63:0]        q;
        s = REG_W'($urandom_range(0, 24'hF00000));
        if ($urandom_range(0, 3) == 0) span = REG_W'($urandom_range(1, 24'hFFFFFF - s));
        else span = REG_W'($urandom_range(1, 24'h40000));
        q = ((64'd1 << 32) + span / 2) / span;
        if (consistent) inv = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[REG_W-1:0];
        else inv = REG_W'($urandom);
        program_taper(s, s + span, inv);
    endtask

    // Aim most radii at the band and its edges; the rest span the full range
    function automatic logic [X_W-1:0] pick_radius();
        int unsigned width;
        case ($urandom_range(0, 7))
            0, 1: return X_W'($urandom);
            2:    return sb.taper_start + X_W'($urandom_range(0, 4)) - X_W'(2);
            3:    return sb.taper_end + X_W'($urandom_range(0, 4)) - X_W'(2);
            default: begin
                if (int'(sb.taper_end) > int'(sb.taper_start) + 1) begin
                    width = 32'(sb.taper_end - sb.taper_start - X_W'(1));
                    return sb.taper_start + X_W'($urandom_range(1, width));
                end
                return X_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic signed [Y_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 6)) - 32'd3;
            default: return 32'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: stall a random number of cycles per word, or hold off
    // for a long stretch when asked, then keep ready high until a word moves
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_requests != holds_taken) begin
                hold = LONG_HOLD;
                holds_taken = hold_requests;
            end else begin
                hold = rx_stalls ? $urandom_range(0, 7) : 0;
            end
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Check every word that moves on the output channel
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_word(tapered_value, region);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: end is zero, so every radius lands in the zero region
        send_word(24'h000000, 32'sd5);
        send_word(24'hFFFFFF, 32'h7FFF_FFFF);

        // Band from 1.0 to 3.0: pass, both band edges, the middle, beyond the end
        drain();
        program_taper(24'h010000, 24'h030000, 24'h008000);
        send_word(24'h000000, 32'h7FFF_FFFF);
        send_word(24'h010000, 32'h8000_0000);
        send_word(24'h010001, 32'h7FFF_FFFF);
        send_word(24'h010001, 32'h8000_0000);
        send_word(24'h020000, 32'h7FFF_FFFF);
        send_word(24'h020000, 32'h8000_0000);
        send_word(24'h020000, 32'sd1);      // half of one lsb rounds away from zero
        send_word(24'h020000, -32'sd1);
        send_word(24'h018000, 32'h1234_5678);
        send_word(24'h02FFFF, 32'h7FFF_FFFF);
        send_word(24'h030000, 32'h7FFF_FFFF);
        send_word(24'hFFFFFF, 32'h8000_0000);

        // End below start: nothing can fall inside the band
        drain();
        program_taper(24'h020000, 24'h010000, 24'h008000);
        send_word(24'h008000, 32'h0001_0000);
        send_word(24'h018000, 32'h0001_0000);
        send_word(24'h020000, 32'hFFFF_0000);

        // Zero inverse span: phase stays at zero, words pass at full weight
        drain();
        program_taper(24'h010000, 24'h020000, 24'h000000);
        send_word(24'h018000, 32'h7FFF_FFFF);
        send_word(24'h01FFFF, 32'h8000_0000);

        // Oversized inverse span: mid-band the phase clamps at one and the weight goes to zero
        drain();
        program_taper(24'h010000, 24'h020000, 24'hFFFFFF);
        send_word(24'h018000, 32'h7FFF_FFFF);
        send_word(24'h010001, 32'h4000_0000);

        // Random phases, each with its own band and idling mix
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: begin
                    program_taper(24'h010000, 24'h030000, 24'h008000);
                    tx_gaps = 1'b1;
                    rx_stalls = 1'b1;
                end
                1: begin
                    // widest band, no idling on either side
                    program_taper(24'h000000, 24'hFFFFFF, 24'h000100);
                    tx_gaps = 1'b0;
                    rx_stalls = 1'b0;
                end
                2: begin
                    // stream flat out while the receiver holds off, so the
                    // pipeline fills and input ready drops
                    program_random_band(1'b1);
                    tx_gaps = 1'b0;
                    rx_stalls = 1'b0;
                    hold_requests++;
                end
                3: begin
                    program_taper(24'h800000, 24'h400000, 24'hFFFFFF);
                    tx_gaps = 1'b1;
                    rx_stalls = 1'b0;
                end
                4: begin
                    program_taper(24'h000000, 24'h7FFFFF, 24'h000000);
                    tx_gaps = 1'b0;
                    rx_stalls = 1'b1;
                end
                5: begin
                    program_random_band(1'b0);
                    tx_gaps = 1'b1;
                    rx_stalls = 1'b1;
                end
                default: begin
                    program_random_band(1'b1);
                    tx_gaps = 1'b1;
                    rx_stalls = phase[0];
                end
            endcase
            repeat (PHASE_WORDS) send_word(pick_radius(), pick_sample());
        end

        // Let the last words out, then allow a few more cycles for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/rct_pkg.sv
sv/raised_cosine_taper_top.sv
dv/testbench.sv
